>>> rtl/wtf_pkg.sv
`default_nettype none

package wtf_pkg;

    // Replacement character for malformed or truncated sequences.
    localparam logic [15:0] REPLACEMENT = 16'hFFFD;

    // Default depth of the job queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // One input word: a raw byte and the end-of-string mark.
    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_input;
    } in_word_t;

    // One output word: a UTF-16 code unit and the end-of-run mark.
    typedef struct packed {
        logic [15:0] code_unit;
        logic        last_of_run;
    } out_word_t;

    // Work for the back: rep replacement units, then tail_n units from unit_a, unit_b.
    typedef struct packed {
        logic [2:0]  rep;
        logic [1:0]  tail_n;
        logic [15:0] unit_a;
        logic [15:0] unit_b;
    } job_t;

    // Front status toward the queue and the top level.
    typedef struct packed {
        logic push;
        logic pending;
    } front_stat_t;

    // Queue status toward the front and the back.
    typedef struct packed {
        logic empty;
        logic full;
    } queue_stat_t;

endpackage

`default_nettype wire

>>> rtl/wtf8_to_wtf16_decoder.sv
// WTF-8 to UTF-16 decoder: one byte in, zero to four code units out.
// The units of a byte pass through the job queue and then the registered output.
// Throughput: one byte per cycle while each byte yields at most one unit and the output
// is not stalled; a byte that yields several units holds the output side until all are
// out, and the two-entry job queue lets input continue meanwhile until it fills.
// Reset: asynchronous, active low; clears the held sequence, the queue and the output valid.
`default_nettype none

module wtf8_to_wtf16_decoder #(
    parameter int QUEUE_DEPTH = wtf_pkg::QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire wtf_pkg::in_word_t  in_word,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output wtf_pkg::out_word_t      out_word
);

    wtf_pkg::front_stat_t f_stat;
    wtf_pkg::queue_stat_t q_stat;
    wtf_pkg::job_t        push_job;
    wtf_pkg::job_t        head_job;
    logic                 pop;

    // Classifies bytes and tracks the sequence in progress.
    wtf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_word  (in_word),
        .in_stall (in_stall),
        .q_stat   (q_stat),
        .f_stat   (f_stat),
        .job      (push_job)
    );

    // Decouples classification from unit emission.
    wtf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (f_stat.push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_stat   (q_stat)
    );

    // Expands each job into code units.
    wtf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    // The front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !f_stat.push)
        else $error("job pushed into full queue");

    // The end-of-string byte always leaves nothing pending.
    a_eoi_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_word.end_of_input) |=> !f_stat.pending)
        else $error("sequence still pending after end of string");

    // The units of one byte follow each other without a gap.
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_word.last_of_run) |=> out_valid)
        else $error("gap inside a run of units");

    // A pop only happens when the queue holds a job.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

>>> rtl/wtf_front.sv
`default_nettype none

module wtf_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire wtf_pkg::in_word_t  in_word,
    output logic                    in_stall,
    input  wire wtf_pkg::queue_stat_t q_stat,
    output wtf_pkg::front_stat_t    f_stat,
    output wtf_pkg::job_t           job
);

    // Sequence state.
    logic [7:0]  held_lead_reg, held_lead_next;
    logic [20:0] partial_reg, partial_next;
    logic [1:0]  held_count_reg, held_count_next;

    logic        accept;
    logic [7:0]  b;
    logic        eoi;
    logic [2:0]  w_in;
    logic [2:0]  w_held;
    logic        lead_ascii;
    logic        lead_rep;
    logic        lead_hold;
    logic [20:0] lead_partial;
    logic [7:0]  cont_lo;
    logic [7:0]  cont_hi;
    logic        cont_ok;
    logic [20:0] cp_next;
    logic [19:0] adj;
    logic [2:0]  cnt;
    wtf_pkg::job_t job_c;

    // Sequence width of a lead byte: 1 ASCII, 2 to 4 multi-byte, 0 invalid.
    function automatic logic [2:0] lead_width(input logic [7:0] v);
        logic [2:0] w;
        begin
            if (v <= 8'h7F)
                w = 3'd1;
            else if (v < 8'hC2)
                w = 3'd0;
            else if (v <= 8'hDF)
                w = 3'd2;
            else if (v <= 8'hEF)
                w = 3'd3;
            else if (v <= 8'hF4)
                w = 3'd4;
            else
                w = 3'd0;
            return w;
        end
    endfunction

    assign in_stall = q_stat.full;
    assign accept   = in_valid && !in_stall;
    assign b        = in_word.byte_in;
    assign eoi      = in_word.end_of_input;

    // Classify the byte as a lead.
    always_comb
    begin
        w_in       = lead_width(b);
        lead_ascii = (w_in == 3'd1);
        lead_rep   = !lead_ascii && ((w_in == 3'd0) || eoi);
        lead_hold  = !lead_ascii && !lead_rep;
        if (w_in == 3'd2)
            lead_partial = {16'd0, b[4:0]};
        else if (w_in == 3'd3)
            lead_partial = {17'd0, b[3:0]};
        else
            lead_partial = {18'd0, b[2:0]};
    end

    // Check the byte as a continuation of the held sequence.
    always_comb
    begin
        w_held  = lead_width(held_lead_reg);
        cont_lo = 8'h80;
        cont_hi = 8'hBF;
        if (held_count_reg == 2'd1)
        begin
            if (held_lead_reg == 8'hE0)
                cont_lo = 8'hA0;
            else if (held_lead_reg == 8'hF0)
                cont_lo = 8'h90;
            else if (held_lead_reg == 8'hF4)
                cont_hi = 8'h8F;
        end
        cont_ok = (b >= cont_lo) && (b <= cont_hi);
        cp_next = {partial_reg[14:0], b[5:0]};
        adj     = cp_next[19:0] - 20'h10000;
        cnt     = {1'b0, held_count_reg} + 3'd1;
    end

    // Build the job and the next sequence state.
    always_comb
    begin
        job_c.rep       = 3'd0;
        job_c.tail_n    = 2'd0;
        job_c.unit_a    = {8'd0, b};
        job_c.unit_b    = 16'hDC00 | {6'd0, adj[9:0]};
        held_lead_next  = held_lead_reg;
        partial_next    = partial_reg;
        held_count_next = held_count_reg;
        if (held_count_reg == 2'd0)
        begin
            job_c.rep    = {2'd0, lead_rep};
            job_c.tail_n = {1'b0, lead_ascii};
            if (lead_hold)
            begin
                held_lead_next  = b;
                held_count_next = 2'd1;
                partial_next    = lead_partial;
            end
        end
        else if (cont_ok)
        begin
            if (cnt >= w_held)
            begin
                // Sequence complete: one unit or a surrogate pair.
                if (cp_next >= 21'h10000)
                begin
                    job_c.tail_n = 2'd2;
                    job_c.unit_a = 16'hD800 | {6'd0, adj[19:10]};
                end
                else
                begin
                    job_c.tail_n = 2'd1;
                    job_c.unit_a = cp_next[15:0];
                end
                held_lead_next  = 8'd0;
                partial_next    = 21'd0;
                held_count_next = 2'd0;
            end
            else if (eoi)
            begin
                // Truncated at end of string: one replacement per byte.
                job_c.rep       = cnt;
                held_lead_next  = 8'd0;
                partial_next    = 21'd0;
                held_count_next = 2'd0;
            end
            else
            begin
                held_count_next = cnt[1:0];
                partial_next    = cp_next;
            end
        end
        else
        begin
            // Bad continuation: replace the held bytes, then retry the byte as a lead.
            job_c.rep       = {1'b0, held_count_reg} + {2'd0, lead_rep};
            job_c.tail_n    = {1'b0, lead_ascii};
            held_lead_next  = 8'd0;
            partial_next    = 21'd0;
            held_count_next = 2'd0;
            if (lead_hold)
            begin
                held_lead_next  = b;
                held_count_next = 2'd1;
                partial_next    = lead_partial;
            end
        end
    end

    assign job            = job_c;
    assign f_stat.push    = accept && ((job_c.rep != 3'd0) || (job_c.tail_n != 2'd0));
    assign f_stat.pending = (held_count_reg != 2'd0);

    // Sequence state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_lead_reg  <= 8'd0;
            partial_reg    <= 21'd0;
            held_count_reg <= 2'd0;
        end
        else if (accept)
        begin
            held_lead_reg  <= held_lead_next;
            partial_reg    <= partial_next;
            held_count_reg <= held_count_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/wtf_queue.sv
`default_nettype none

module wtf_queue #(
    parameter int DEPTH = wtf_pkg::QUEUE_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire wtf_pkg::job_t       push_job,
    input  wire logic                pop,
    output wtf_pkg::job_t            head_job,
    output wtf_pkg::queue_stat_t     q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wtf_pkg::job_t     mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign q_stat.empty = (count_reg == '0);
    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head_job     = mem[rd_ptr_reg];

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_job;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> rtl/wtf_back.sv
`default_nettype none

module wtf_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire wtf_pkg::job_t        head_job,
    input  wire wtf_pkg::queue_stat_t q_stat,
    output logic                      pop,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output wtf_pkg::out_word_t        out_word
);

    logic [2:0]         idx_reg;
    logic [2:0]         idx_next;
    logic               out_valid_reg;
    wtf_pkg::out_word_t out_word_reg;
    wtf_pkg::out_word_t unit_c;
    logic [2:0]         total;
    logic               last;
    logic               advance;

    // Pick the unit of the head job at the current position.
    always_comb
    begin
        total = head_job.rep + {1'b0, head_job.tail_n};
        last  = (idx_reg == total - 3'd1);
        if (idx_reg < head_job.rep)
            unit_c.code_unit = wtf_pkg::REPLACEMENT;
        else if (idx_reg == head_job.rep)
            unit_c.code_unit = head_job.unit_a;
        else
            unit_c.code_unit = head_job.unit_b;
        unit_c.last_of_run = last;
    end

    assign advance  = !q_stat.empty && (!out_valid_reg || !out_stall);
    assign pop      = advance && last;
    assign idx_next = last ? 3'd0 : idx_reg + 3'd1;

    // Output register and position within the job.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                idx_reg <= idx_next;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_word_reg <= unit_c;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

`default_nettype wire
